// File: rtl/rgb_to_hsv_converter_macros.svh
// ----------------------------------------------------------------------------
// RGB to HSV converter assertion macros
// Shared concurrent assertion shorthands for the converter checkers.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RHC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rgb_to_hsv_converter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RHC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rgb_to_hsv_converter: next-cycle check failed");

`endif

// File: rtl/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Beat types, widths and constants shared by the converter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgbhsv_pkg;

    localparam int PIX_W         = 8;
    localparam int NUM_W         = 11;
    localparam int NUM15_W       = 15;
    localparam int REM_W         = 16;
    localparam int DEN_W         = 15;
    localparam int QUO_W         = 16;
    localparam int HUE_W         = 15;
    localparam int SAT_W         = 16;
    localparam int N_CELLS       = 16;
    localparam int HUE_DEN_SHIFT = 7;

    localparam logic [SAT_W-1:0] SAT_ONE   = 16'd32768;
    localparam logic [HUE_W-1:0] HUE_LIMIT = 15'd23040;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] saturation;
        logic [PIX_W-1:0] brightness;
    } t_hsv;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } t_lane;

    typedef struct packed {
        t_lane            hue;
        t_lane            sat;
        logic [PIX_W-1:0] brightness;
    } t_stage;

endpackage

`default_nettype wire

// File: rtl/rgbhsv_prep.sv
// ----------------------------------------------------------------------------
// RGB to HSV front end
// Finds max, min and spread, picks the hue sector and loads both divider lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbhsv_prep (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire rgbhsv_pkg::t_pixel i_data,
    output logic                   o_ready,
    input  wire logic              i_ready_next,
    output logic                   o_valid,
    output rgbhsv_pkg::t_stage     o_data
);
    import rgbhsv_pkg::*;

    logic               r_valid;
    t_stage             r_data;
    t_stage             n_data;
    logic [PIX_W-1:0]   mx;
    logic [PIX_W-1:0]   mn;
    logic [PIX_W-1:0]   diff;
    logic [NUM_W-1:0]   r11;
    logic [NUM_W-1:0]   g11;
    logic [NUM_W-1:0]   b11;
    logic [NUM_W-1:0]   d11;
    logic [NUM_W-1:0]   num;
    logic [NUM15_W-1:0] num15;

    assign o_ready = !r_valid || i_ready_next;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        mx = i_data.red;
        if (i_data.green > mx) begin
            mx = i_data.green;
        end
        if (i_data.blue > mx) begin
            mx = i_data.blue;
        end
        mn = i_data.red;
        if (i_data.green < mn) begin
            mn = i_data.green;
        end
        if (i_data.blue < mn) begin
            mn = i_data.blue;
        end
        diff = mx - mn;

        // Sector sums are never negative and stay below 2048, so 11-bit wrap is exact.
        r11 = {3'b000, i_data.red};
        g11 = {3'b000, i_data.green};
        b11 = {3'b000, i_data.blue};
        d11 = {3'b000, diff};
        if (mx == i_data.red) begin
            if (i_data.green >= i_data.blue) begin
                num = g11 - b11;
            end else begin
                num = (d11 << 2) + (d11 << 1) + g11 - b11;
            end
        end else if (mx == i_data.green) begin
            num = (d11 << 1) + b11 - r11;
        end else begin
            num = (d11 << 2) + r11 - g11;
        end
        num15 = ({4'b0000, num} << 4) - {4'b0000, num};

        n_data.hue.rem = {1'b0, num15};
        n_data.hue.den = (diff == '0) ? DEN_W'(1) : {diff, {HUE_DEN_SHIFT{1'b0}}};
        n_data.hue.quo = '0;
        n_data.sat.rem = {{(REM_W-PIX_W){1'b0}}, diff};
        n_data.sat.den = (mx == '0) ? DEN_W'(1) : {{(DEN_W-PIX_W){1'b0}}, mx};
        n_data.sat.quo = '0;
        n_data.brightness = mx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rgbhsv_cell.sv
// ----------------------------------------------------------------------------
// RGB to HSV divider cell
// One restoring division step on the hue and saturation lanes, then a register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbhsv_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire rgbhsv_pkg::t_stage i_data,
    output logic                   o_ready,
    input  wire logic              i_ready_next,
    output logic                   o_valid,
    output rgbhsv_pkg::t_stage     o_data
);
    import rgbhsv_pkg::*;

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;

    function automatic t_lane lane_step(input t_lane lane);
        t_lane            res;
        logic             ge;
        logic [REM_W-1:0] part;
        ge   = lane.rem >= {1'b0, lane.den};
        part = ge ? (lane.rem - {1'b0, lane.den}) : lane.rem;
        res.rem = {part[REM_W-2:0], 1'b0};
        res.den = lane.den;
        res.quo = {lane.quo[QUO_W-2:0], ge};
        return res;
    endfunction

    assign o_ready = !r_valid || i_ready_next;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data.hue        = lane_step(i_data.hue);
        n_data.sat        = lane_step(i_data.sat);
        n_data.brightness = i_data.brightness;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Converts one 8-bit RGB pixel per beat into hue, saturation and value.
// ----------------------------------------------------------------------------
//  channel | valid        | stall        | payload
//  input   | i_in_valid   | o_in_stall   | i_in_data  (red, green, blue)
//  output  | o_out_valid  | i_out_stall  | o_out_data (hue, saturation, brightness)
//
//  One pixel per cycle is taken while o_in_stall is low; a result passes the front-end register and each cell register.
//  The pipeline is one front-end stage plus a row of 16 divider cells, one
//  quotient bit per cell, for both hue and saturation in parallel.
//  Reset clears only the stage valid bits.
//  An output stall reaches the input in the same cycle once every stage is
//  full; empty stages keep filling while the output waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire rgbhsv_pkg::t_pixel i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output rgbhsv_pkg::t_hsv       o_out_data
);
    import rgbhsv_pkg::*;

    logic   prep_ready;
    logic   stg_valid [N_CELLS+1];
    logic   stg_ready [N_CELLS+1];
    t_stage stg_data  [N_CELLS+1];

    assign o_in_stall = !prep_ready;

    rgbhsv_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_data       (i_in_data),
        .o_ready      (prep_ready),
        .i_ready_next (stg_ready[0]),
        .o_valid      (stg_valid[0]),
        .o_data       (stg_data[0])
    );

    for (genvar gi = 0; gi < N_CELLS; gi++) begin : g_cell
        rgbhsv_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (stg_valid[gi]),
            .i_data       (stg_data[gi]),
            .o_ready      (stg_ready[gi]),
            .i_ready_next (stg_ready[gi+1]),
            .o_valid      (stg_valid[gi+1]),
            .o_data       (stg_data[gi+1])
        );
    end

    assign stg_ready[N_CELLS] = !i_out_stall;
    assign o_out_valid        = stg_valid[N_CELLS];

    always_comb begin
        o_out_data.hue        = stg_data[N_CELLS].hue.quo[HUE_W-1:0];
        o_out_data.saturation = stg_data[N_CELLS].sat.quo[SAT_W-1:0];
        o_out_data.brightness = stg_data[N_CELLS].brightness;
    end

endmodule

`default_nettype wire

// File: rtl/rgbhsv_checker.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter checker
// Port-level assertions on the converter, attached by a bind statement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_to_hsv_converter_macros.svh"

module rgbhsv_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_stall,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire rgbhsv_pkg::t_hsv  i_out_data
);
    import rgbhsv_pkg::*;

    logic out_held;
    logic black_out;
    logic black_hsv;

    assign out_held  = i_out_valid && i_out_stall;
    assign black_out = i_out_valid && (i_out_data.brightness == '0);
    assign black_hsv = (i_out_data.saturation == '0) && (i_out_data.hue == '0);

    `RHC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, i_out_valid && $stable(i_out_data))
    `RHC_ASSERT_SAME(a_sat_range, i_clk, i_rst_n, i_out_valid, i_out_data.saturation <= SAT_ONE)
    `RHC_ASSERT_SAME(a_hue_range, i_clk, i_rst_n, i_out_valid, i_out_data.hue < HUE_LIMIT)
    `RHC_ASSERT_SAME(a_black, i_clk, i_rst_n, black_out, black_hsv)
    `RHC_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, i_in_stall, out_held)

endmodule

bind rgb_to_hsv_converter rgbhsv_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

`default_nettype wire
